>>> design/dqdel_pkg.sv
// Shared types and codes for the double-ended queue with delete by value.
package dqdel_pkg;

    localparam int WORD_W    = 32;
    localparam int DEPTH_DEF = 16;
    localparam int COUNT_W   = 5;

    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_DELETE     = 3'd4;
    localparam logic [2:0] ACT_CLEAR      = 3'd5;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [WORD_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
        logic signed [WORD_W-1:0] front_word;
        logic signed [WORD_W-1:0] back_word;
    } rsp_t;

    // Row-wide control, one copy seen by every cell
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic del_en;
        logic back_only;
    } cell_ctrl_t;

    typedef struct packed {
        logic hit;
        logic back_hit;
    } cell_stat_t;

endpackage

>>> design/dqdel_cell.sv
// One entry cell of the queue row: holds a word, matches it, shifts with its neighbours.
module dqdel_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                               clk,
    input  dqdel_pkg::cell_ctrl_t              ctrl,
    input  logic signed [dqdel_pkg::WORD_W-1:0] value,
    input  logic [CNT_W-1:0]                   count,
    input  logic signed [dqdel_pkg::WORD_W-1:0] left_word,
    input  logic signed [dqdel_pkg::WORD_W-1:0] right_word,
    input  logic                               found_in,
    output logic                               found_out,
    output dqdel_pkg::cell_stat_t              stat,
    output logic signed [dqdel_pkg::WORD_W-1:0] word,
    output logic signed [dqdel_pkg::WORD_W-1:0] tap
);

    logic signed [dqdel_pkg::WORD_W-1:0] word_reg;
    logic signed [dqdel_pkg::WORD_W-1:0] word_next;
    logic occupied;
    logic is_tail;
    logic is_last;
    logic hit;
    logic del_shift;

    assign occupied = count > CNT_W'(IDX);
    assign is_tail  = count == CNT_W'(IDX);
    assign is_last  = count == CNT_W'(IDX + 1);
    assign hit      = occupied && (word_reg == value);

    assign found_out     = found_in | hit;
    assign stat.hit      = hit;
    assign stat.back_hit = hit & is_last;

    // from the first match onwards the row closes the gap
    assign del_shift = ctrl.del_en & ~ctrl.back_only & (found_in | hit);

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.push_front)
        begin
            word_next = left_word;
        end
        else if (ctrl.push_back && is_tail)
        begin
            word_next = value;
        end
        else if (ctrl.pop_front || del_shift)
        begin
            word_next = right_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    assign tap  = is_last ? word_reg : '0;

endmodule

>>> design/deque_with_delete_by_value.sv
// Top level of the bounded double-ended queue with delete by value.
// A row of DEPTH entry cells holds the queue with the front in cell 0. Every
// action (push front/back, pop front/back, delete by value, clear) takes effect
// when accepted; the result is registered and a new item is taken in the same
// cycle the previous result is taken, so the block sustains one item per cycle
// unless stalled. The match chain that ripples along the cell row for delete,
// and the selection of the back entry, set the clock period. A full push is
// rejected with status 2; pops and deletes on an empty queue report status 1.
module deque_with_delete_by_value #(
    parameter int DEPTH = dqdel_pkg::DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  dqdel_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output dqdel_pkg::rsp_t  rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    logic accept;
    logic empty;
    logic full;
    logic back_hit_any;
    logic found_any;
    logic signed [dqdel_pkg::WORD_W-1:0] back_sel;

    dqdel_pkg::cell_ctrl_t ctrl;
    dqdel_pkg::cell_stat_t stat [DEPTH];
    logic signed [dqdel_pkg::WORD_W-1:0] words [DEPTH];
    logic signed [dqdel_pkg::WORD_W-1:0] taps  [DEPTH];
    logic found [DEPTH+1];

    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;
    assign empty     = count_reg == '0;
    assign full      = count_reg == CNT_W'(DEPTH);
    assign found[0]  = 1'b0;
    assign found_any = found[DEPTH];

    always_comb
    begin
        back_hit_any = 1'b0;
        back_sel     = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_hit_any = back_hit_any | stat[i].back_hit;
            back_sel     = back_sel | taps[i];
        end
    end

    always_comb
    begin
        ctrl.push_front = accept && (req.action == dqdel_pkg::ACT_PUSH_FRONT) && !full;
        ctrl.push_back  = accept && (req.action == dqdel_pkg::ACT_PUSH_BACK) && !full;
        ctrl.pop_front  = accept && (req.action == dqdel_pkg::ACT_POP_FRONT) && !empty;
        ctrl.del_en     = accept && (req.action == dqdel_pkg::ACT_DELETE);
        // back entry wins over middle matches unless the front matched
        ctrl.back_only  = back_hit_any & ~stat[0].hit;
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [dqdel_pkg::WORD_W-1:0] left_w;
        logic signed [dqdel_pkg::WORD_W-1:0] right_w;

        if (g == 0)
        begin : g_head
            assign left_w = req.value;
        end
        else
        begin : g_body
            assign left_w = words[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_end
            assign right_w = words[g];
        end
        else
        begin : g_mid
            assign right_w = words[g+1];
        end

        dqdel_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .value      (req.value),
            .count      (count_reg),
            .left_word  (left_w),
            .right_word (right_w),
            .found_in   (found[g]),
            .found_out  (found[g+1]),
            .stat       (stat[g]),
            .word       (words[g]),
            .tap        (taps[g])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = dqdel_pkg::ST_DONE;
        case (req.action)
            dqdel_pkg::ACT_PUSH_FRONT,
            dqdel_pkg::ACT_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = dqdel_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            dqdel_pkg::ACT_POP_FRONT,
            dqdel_pkg::ACT_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = dqdel_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            dqdel_pkg::ACT_DELETE:
            begin
                if (empty)
                begin
                    status_next = dqdel_pkg::ST_EMPTY;
                end
                else if (found_any)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = dqdel_pkg::ST_NOT_FOUND;
                end
            end
            dqdel_pkg::ACT_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    // state only moves on accept, so the fields hold while the result waits
    assign rsp_valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.count       = dqdel_pkg::COUNT_W'(count_reg);
    assign rsp.front_word  = empty ? '0 : words[0];
    assign rsp.back_word   = empty ? '0 : back_sel;

endmodule
